// ===== rtl/swsr_pkg.sv =====
package swsr_pkg;

  // Frame length in data bits (humidity, temperature, checksum)
  localparam int FRAME_BITS = 40;
  localparam logic [5:0] FRAME_BITS_W = 6'(FRAME_BITS);

  // Bit counts at which the data words are latched
  localparam logic [5:0] HUMIDITY_BIT    = 6'd16;
  localparam logic [5:0] TEMPERATURE_BIT = 6'd32;

  // Configuration register indexes
  localparam logic CFG_HOST_LOW_TICKS = 1'b0;
  localparam logic CFG_ONE_BIT_TICKS  = 1'b1;

  // Configuration reset values
  localparam logic [7:0] HOST_LOW_TICKS_RST = 8'd100;
  localparam logic [7:0] ONE_BIT_TICKS_RST  = 8'd4;

  // Read sequencer phases
  localparam logic [2:0] PH_IDLE         = 3'd0;
  localparam logic [2:0] PH_HOST_LOW     = 3'd1;
  localparam logic [2:0] PH_HOST_RELEASE = 3'd2;
  localparam logic [2:0] PH_RESP_LOW     = 3'd3;
  localparam logic [2:0] PH_RESP_HIGH    = 3'd4;
  localparam logic [2:0] PH_BIT_PREP     = 3'd5;
  localparam logic [2:0] PH_BIT_HIGH     = 3'd6;
  localparam logic [2:0] PH_DONE         = 3'd7;

  // One result transaction
  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] humidity_word;
    logic [15:0] temperature_word;
  } result_t;

endpackage

// ===== rtl/swsr_core.sv =====
module swsr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              command,
  input  logic              pin_level,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  output swsr_pkg::result_t result
);

  logic [7:0]  host_low_ticks;
  logic [7:0]  one_bit_ticks;

  logic [2:0]  phase,      phase_next;
  logic [7:0]  tick_count, tick_count_next;
  logic [5:0]  bit_count,  bit_count_next;
  logic [15:0] shift_word, shift_word_next;
  logic [15:0] humidity_reg,    humidity_reg_next;
  logic [15:0] temperature_reg, temperature_reg_next;

  logic [7:0]  tick_inc;
  logic [5:0]  bit_inc;
  logic [15:0] shifted;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      host_low_ticks <= swsr_pkg::HOST_LOW_TICKS_RST;
      one_bit_ticks  <= swsr_pkg::ONE_BIT_TICKS_RST;
    end else if (cfg_we) begin
      if (cfg_index == swsr_pkg::CFG_HOST_LOW_TICKS) begin
        host_low_ticks <= cfg_data;
      end else begin
        one_bit_ticks <= cfg_data;
      end
    end
  end

  // Saturating tick count, next bit and shifted word
  assign tick_inc = (tick_count != 8'hFF) ? tick_count + 8'd1 : tick_count;
  assign bit_inc  = bit_count + 6'd1;
  assign shifted  = {shift_word[14:0], (tick_inc > one_bit_ticks)};

  // Sequencer next state
  always_comb begin
    phase_next           = phase;
    tick_count_next      = tick_count;
    bit_count_next       = bit_count;
    shift_word_next      = shift_word;
    humidity_reg_next    = humidity_reg;
    temperature_reg_next = temperature_reg;
    if (command) begin
      phase_next      = swsr_pkg::PH_HOST_LOW;
      tick_count_next = 8'd0;
      bit_count_next  = 6'd0;
      shift_word_next = 16'd0;
    end else begin
      tick_count_next = tick_inc;
      case (phase)
        swsr_pkg::PH_HOST_LOW: begin
          if (tick_inc >= host_low_ticks) begin
            tick_count_next = 8'd0;
            phase_next      = swsr_pkg::PH_HOST_RELEASE;
          end
        end
        swsr_pkg::PH_HOST_RELEASE: begin
          if (!pin_level) begin
            tick_count_next = 8'd0;
            phase_next      = swsr_pkg::PH_RESP_LOW;
          end
        end
        swsr_pkg::PH_RESP_LOW: begin
          if (pin_level) begin
            tick_count_next = 8'd0;
            phase_next      = swsr_pkg::PH_RESP_HIGH;
          end
        end
        swsr_pkg::PH_RESP_HIGH: begin
          if (!pin_level) begin
            tick_count_next = 8'd0;
            phase_next      = swsr_pkg::PH_BIT_PREP;
          end
        end
        swsr_pkg::PH_BIT_PREP: begin
          if (pin_level) begin
            tick_count_next = 8'd0;
            phase_next      = swsr_pkg::PH_BIT_HIGH;
          end
        end
        swsr_pkg::PH_BIT_HIGH: begin
          // falling edge ends the bit: sample its high time
          if (!pin_level) begin
            bit_count_next  = bit_inc;
            shift_word_next = shifted;
            if (bit_inc == swsr_pkg::HUMIDITY_BIT) begin
              humidity_reg_next = shifted;
              shift_word_next   = 16'd0;
            end
            if (bit_inc == swsr_pkg::TEMPERATURE_BIT) begin
              temperature_reg_next = shifted;
              shift_word_next      = 16'd0;
            end
            if (bit_inc == swsr_pkg::FRAME_BITS_W) begin
              phase_next = swsr_pkg::PH_DONE;
            end else begin
              tick_count_next = 8'd0;
              phase_next      = swsr_pkg::PH_BIT_PREP;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= swsr_pkg::PH_IDLE;
      tick_count      <= 8'd0;
      bit_count       <= 6'd0;
      shift_word      <= 16'd0;
      humidity_reg    <= 16'd0;
      temperature_reg <= 16'd0;
    end else if (fire) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      bit_count       <= bit_count_next;
      shift_word      <= shift_word_next;
      humidity_reg    <= humidity_reg_next;
      temperature_reg <= temperature_reg_next;
    end
  end

  // Result seen after the update
  always_comb begin
    result.drive_low        = (phase_next == swsr_pkg::PH_HOST_LOW);
    result.busy_res         = (phase_next != swsr_pkg::PH_IDLE) &&
                              (phase_next != swsr_pkg::PH_DONE);
    result.done_res         = (phase_next == swsr_pkg::PH_DONE);
    result.humidity_word    = humidity_reg_next;
    result.temperature_word = temperature_reg_next;
  end

endmodule

// ===== rtl/swsr_out_buf.sv =====
module swsr_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  swsr_pkg::result_t in_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output swsr_pkg::result_t out_data
);

  logic              skid_valid;
  swsr_pkg::result_t skid_data;
  logic              out_free;

  assign full     = skid_valid;
  assign out_free = !out_valid || !out_stall;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (!out_free && in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== rtl/single_wire_sensor_reader.sv =====
// Host side of a single-wire humidity/temperature sensor read. Each input
// transaction is one timer tick with a sampled pin level (command 0) or a start
// request (command 1); every input transaction yields exactly one result
// transaction carrying drive_low, busy/done status and the last latched
// humidity and temperature words. One transaction is accepted per clock: the
// sequencer state updates in a single registered pass, and results go through
// an output register with a one-entry skid, so item_stall rises only when both
// are full. Configuration (host_low_ticks at index 0, one_bit_ticks at index 1)
// is always ready and must be written only while the block is idle.
module single_wire_sensor_reader (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        command,
  input  logic        pin_level,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        drive_low,
  output logic        busy_res,
  output logic        done_res,
  output logic [15:0] humidity_word,
  output logic [15:0] temperature_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic              fire;
  logic              buf_full;
  swsr_pkg::result_t core_result;
  swsr_pkg::result_t out_result;

  assign cfg_ready  = 1'b1;
  assign item_stall = buf_full;
  assign fire       = item_valid && !buf_full;

  // Sequencer and configuration registers
  swsr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .command   (command),
    .pin_level (pin_level),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (core_result)
  );

  // Result buffering
  swsr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (fire),
    .in_data   (core_result),
    .full      (buf_full),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (out_result)
  );

  assign drive_low        = out_result.drive_low;
  assign busy_res         = out_result.busy_res;
  assign done_res         = out_result.done_res;
  assign humidity_word    = out_result.humidity_word;
  assign temperature_word = out_result.temperature_word;

endmodule

// ===== tb/sensor_read_checker.sv =====
module sensor_read_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic        command,
  input  logic        pin_level,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        drive_low,
  input  logic        busy_res,
  input  logic        done_res,
  input  logic [15:0] humidity_word,
  input  logic [15:0] temperature_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending_count,
  output int          compared_count
);

  // Shadow copy of the configuration registers
  logic [7:0]  host_low_ticks;
  logic [7:0]  one_threshold;

  // Shadow copy of the read sequencer
  logic [2:0]  phase;
  logic [7:0]  tick_cnt;
  logic [5:0]  bit_cnt;
  logic [15:0] shift_word;
  logic [15:0] humidity_reg;
  logic [15:0] temperature_reg;

  swsr_pkg::result_t expected_readings[$];
  int          errors;
  int          compared;

  // Advance the shadow sequencer by one input transaction
  task automatic advance_reader(input logic start, input logic pin);
    if (start) begin
      phase      = swsr_pkg::PH_HOST_LOW;
      tick_cnt   = '0;
      bit_cnt    = '0;
      shift_word = '0;
    end else begin
      if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 8'd1;
      case (phase)
        swsr_pkg::PH_HOST_LOW: begin
          if (tick_cnt >= host_low_ticks) begin
            tick_cnt = '0;
            phase    = swsr_pkg::PH_HOST_RELEASE;
          end
        end
        swsr_pkg::PH_HOST_RELEASE: begin
          if (!pin) begin
            tick_cnt = '0;
            phase    = swsr_pkg::PH_RESP_LOW;
          end
        end
        swsr_pkg::PH_RESP_LOW: begin
          if (pin) begin
            tick_cnt = '0;
            phase    = swsr_pkg::PH_RESP_HIGH;
          end
        end
        swsr_pkg::PH_RESP_HIGH: begin
          if (!pin) begin
            tick_cnt = '0;
            phase    = swsr_pkg::PH_BIT_PREP;
          end
        end
        swsr_pkg::PH_BIT_PREP: begin
          if (pin) begin
            tick_cnt = '0;
            phase    = swsr_pkg::PH_BIT_HIGH;
          end
        end
        swsr_pkg::PH_BIT_HIGH: begin
          // falling edge ends the bit; long high time reads as one
          if (!pin) begin
            bit_cnt    = bit_cnt + 6'd1;
            shift_word = {shift_word[14:0], tick_cnt > one_threshold};
            if (bit_cnt == swsr_pkg::HUMIDITY_BIT) begin
              humidity_reg = shift_word;
              shift_word   = '0;
            end
            if (bit_cnt == swsr_pkg::TEMPERATURE_BIT) begin
              temperature_reg = shift_word;
              shift_word      = '0;
            end
            if (bit_cnt == swsr_pkg::FRAME_BITS_W) begin
              phase = swsr_pkg::PH_DONE;
            end else begin
              tick_cnt = '0;
              phase    = swsr_pkg::PH_BIT_PREP;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Watch the channels: configuration, results, then new inputs
  always @(posedge clk) begin
    swsr_pkg::result_t want;
    if (rst) begin
      host_low_ticks  = swsr_pkg::HOST_LOW_TICKS_RST;
      one_threshold   = swsr_pkg::ONE_BIT_TICKS_RST;
      phase           = swsr_pkg::PH_IDLE;
      tick_cnt        = '0;
      bit_cnt         = '0;
      shift_word      = '0;
      humidity_reg    = '0;
      temperature_reg = '0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == swsr_pkg::CFG_HOST_LOW_TICKS) host_low_ticks = cfg_data;
        else one_threshold = cfg_data;
      end

      if (result_valid && !result_stall) begin
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing expected", $time);
        end else begin
          want = expected_readings.pop_front();
          compared++;
          check_field("drive_low", want.drive_low, drive_low);
          check_field("busy_res", want.busy_res, busy_res);
          check_field("done_res", want.done_res, done_res);
          check_field("humidity_word", want.humidity_word, humidity_word);
          check_field("temperature_word", want.temperature_word, temperature_word);
        end
      end

      if (item_valid && !item_stall) begin
        advance_reader(command, pin_level);
        want.drive_low        = (phase == swsr_pkg::PH_HOST_LOW);
        want.busy_res         = (phase != swsr_pkg::PH_IDLE) &&
                                (phase != swsr_pkg::PH_DONE);
        want.done_res         = (phase == swsr_pkg::PH_DONE);
        want.humidity_word    = humidity_reg;
        want.temperature_word = temperature_reg;
        expected_readings.push_back(want);
      end
    end
    fail_count     <= errors;
    pending_count  <= expected_readings.size();
    compared_count <= compared;
  end

endmodule

// ===== tb/tb_single_wire_sensor_reader.sv =====
module tb_single_wire_sensor_reader;

  localparam logic CMD_TICK       = 1'b0;
  localparam logic CMD_START      = 1'b1;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   RANDOM_ITEMS   = 400;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        command      = 1'b0;
  logic        pin_level    = 1'b0;
  logic        result_stall = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic        cfg_index    = 1'b0;
  logic [7:0]  cfg_data     = 8'd0;

  logic        item_stall;
  logic        result_valid;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic [15:0] humidity_word;
  logic [15:0] temperature_word;
  logic        cfg_ready;

  int          fail_count;
  int          pending_count;
  int          compared_count;

  int          items_sent;
  int          frames_sent;
  int          frames_cut;
  logic [7:0]  host_low_setting = swsr_pkg::HOST_LOW_TICKS_RST;
  logic [7:0]  one_thr_setting  = swsr_pkg::ONE_BIT_TICKS_RST;
  bit          steady_input;

  always #4 clk = ~clk;

  single_wire_sensor_reader u_top (.*);

  sensor_read_checker u_checker (.*);

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle_len(input bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // One input transaction, after an optional gap
  task automatic drive_sample(input logic cmd, input logic pin);
    int gap;
    bit taken;
    gap = pick_idle_len(steady_input);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    command    <= cmd;
    pin_level  <= pin;
    do begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic hold_pin(input logic level, input int n);
    repeat (n) drive_sample(CMD_TICK, level);
  endtask

  // Random ticks with the occasional stray start
  task automatic send_noise(input int n);
    repeat (n) begin
      drive_sample(($urandom_range(0, 9) == 0) ? CMD_START : CMD_TICK,
                   1'($urandom_range(0, 1)));
    end
  endtask

  task automatic write_register(input logic idx, input logic [7:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    if (idx == swsr_pkg::CFG_HOST_LOW_TICKS) host_low_setting = value;
    else one_thr_setting = value;
    @(posedge clk);
  endtask

  // Stop input and wait until every result has come back
  task automatic settle_block();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (3) @(posedge clk);
  endtask

  // Well-formed sensor read with random timing; may stop early at cut_bit,
  // and holds bit long_bit high long enough to saturate the tick counter
  task automatic run_read_frame(input int cut_bit, input int long_bit);
    int b;
    int hi_len;
    int lo;
    steady_input = ($urandom_range(0, 3) == 0);
    frames_sent++;
    drive_sample(CMD_START, 1'($urandom_range(0, 1)));
    repeat ((host_low_setting == 0) ? 1 : host_low_setting)
      drive_sample(CMD_TICK, 1'($urandom_range(0, 1)));
    // release, sensor response low, response high
    hold_pin(1'b1, $urandom_range(0, 3));
    hold_pin(1'b0, 1 + $urandom_range(0, 3));
    hold_pin(1'b1, 1 + $urandom_range(0, 3));
    hold_pin(1'b0, 1);
    for (b = 0; b < swsr_pkg::FRAME_BITS; b++) begin
      if (b == cut_bit) begin
        frames_cut++;
        break;
      end
      hold_pin(1'b0, $urandom_range(0, 2));
      hold_pin(1'b1, 1);
      if (b == long_bit) begin
        hi_len = 300;
      end else if (one_thr_setting > 8) begin
        hi_len = $urandom_range(0, 4);
      end else begin
        lo     = (one_thr_setting >= 2) ? one_thr_setting - 2 : 0;
        hi_len = $urandom_range(lo, one_thr_setting + 1);
      end
      hold_pin(1'b1, hi_len);
      hold_pin(1'b0, 1);
    end
    steady_input = 1'b0;
  endtask

  // Result side stalls, with stretches of no stalling
  initial begin
    int stall_left;
    int steady_left;
    stall_left  = 0;
    steady_left = 0;
    forever begin
      @(posedge clk);
      if (steady_left > 0) steady_left--;
      else if ($urandom_range(0, 299) == 0) steady_left = $urandom_range(50, 200);
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
        if (steady_left == 0 && $urandom_range(0, 3) == 0)
          stall_left = pick_idle_len(1'b0);
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int random_start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: idle ticks, start ignoring pin, restart during host low
    drive_sample(CMD_TICK, 1'b0);
    drive_sample(CMD_TICK, 1'b1);
    drive_sample(CMD_START, 1'b1);
    hold_pin(1'b0, 2);
    hold_pin(1'b1, 2);
    drive_sample(CMD_START, 1'b0);
    hold_pin(1'b1, 3);
    hold_pin(1'b0, 3);
    drive_sample(CMD_START, 1'b1);
    drive_sample(CMD_TICK, 1'b1);
    settle_block();

    // zero-length host low, lowest threshold: every bit reads as one
    write_register(swsr_pkg::CFG_HOST_LOW_TICKS, 8'd0);
    write_register(swsr_pkg::CFG_ONE_BIT_TICKS, 8'd0);
    run_read_frame(-1, -1);
    hold_pin(1'b1, 3);
    settle_block();

    // longest host low; one bit held past tick counter saturation
    write_register(swsr_pkg::CFG_HOST_LOW_TICKS, 8'd255);
    write_register(swsr_pkg::CFG_ONE_BIT_TICKS, 8'd254);
    run_read_frame(-1, 20);
    send_noise(4);
    settle_block();

    // highest threshold: no bit can read as one
    write_register(swsr_pkg::CFG_HOST_LOW_TICKS, 8'd1);
    write_register(swsr_pkg::CFG_ONE_BIT_TICKS, 8'd255);
    run_read_frame(-1, -1);
    settle_block();

    // random settings, mostly complete frames with some cut short
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      write_register(swsr_pkg::CFG_HOST_LOW_TICKS, 8'($urandom_range(1, 8)));
      write_register(swsr_pkg::CFG_ONE_BIT_TICKS, 8'($urandom_range(0, 6)));
      repeat ($urandom_range(1, 3)) begin
        send_noise($urandom_range(0, 6));
        run_read_frame(($urandom_range(0, 6) == 0) ?
                       int'($urandom_range(0, swsr_pkg::FRAME_BITS - 1)) : -1, -1);
      end
      send_noise($urandom_range(0, 4));
      settle_block();
    end

    $display("Covered %0d input transactions in %0d read frames (%0d cut short),",
             items_sent, frames_sent, frames_cut);
    $display("with host low time and bit threshold at 0 and 255; %0d results compared.",
             compared_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/swsr_pkg.sv
rtl/swsr_core.sv
rtl/swsr_out_buf.sv
rtl/single_wire_sensor_reader.sv
tb/sensor_read_checker.sv
tb/tb_single_wire_sensor_reader.sv
